@@ rtl/core/dltq_pkg.sv @@
`default_nettype none

package dltq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int DELTA_W = 16;
    localparam int TAG_W = 16;
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = DELTA_W + IDX_W;
    localparam int S_TDATA_W = ((DELTA_W + TAG_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((TAG_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_EXPIRED = 1'b0;
    localparam logic KIND_REJECTED = 1'b1;

    typedef struct packed {
        logic start_insert;
        logic walk_adv;
        logic insert_shift;
        logic tick_dec;
        logic pop;
        logic load_reject;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic head_one;
        logic walk_end;
        logic walk_hit;
        logic pop_last;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ rtl/core/dltq_ctrl.sv @@
`default_nettype none

module dltq_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             i_operation,
    output logic                  o_ready,
    input  wire dltq_pkg::t_status i_status,
    output dltq_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_POP   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_ready = (r_state == S_IDLE) && i_status.out_free;
    assign accept = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == dltq_pkg::OP_INSERT) begin
                        if (i_status.full) begin
                            o_cmd.load_reject = 1'b1;
                        end else begin
                            o_cmd.start_insert = 1'b1;
                            n_state = S_WALK;
                        end
                    end else if (!i_status.empty) begin
                        o_cmd.tick_dec = 1'b1;
                        if (i_status.head_one) begin
                            n_state = S_POP;
                        end
                    end
                end
            end
            S_WALK: begin
                if (i_status.walk_end || i_status.walk_hit) begin
                    n_state = S_SHIFT;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                end
            end
            S_SHIFT: begin
                o_cmd.insert_shift = 1'b1;
                n_state = S_IDLE;
            end
            S_POP: begin
                if (i_status.out_free) begin
                    o_cmd.pop = 1'b1;
                    if (i_status.pop_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/dltq_dp.sv @@
`default_nettype none

module dltq_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dltq_pkg::t_cmd                i_cmd,
    output dltq_pkg::t_status                  o_status,
    input  wire logic [dltq_pkg::DELTA_W-1:0]  i_delay,
    input  wire logic [dltq_pkg::TAG_W-1:0]    i_tag,
    input  wire logic                          i_m_tready,
    output logic                               o_m_tvalid,
    output logic                               o_m_kind,
    output logic [dltq_pkg::TAG_W-1:0]         o_m_tag,
    output logic                               o_m_last
);

    logic [dltq_pkg::DELTA_W-1:0] r_delta [dltq_pkg::QUEUE_DEPTH];
    logic [dltq_pkg::DELTA_W-1:0] n_delta [dltq_pkg::QUEUE_DEPTH];
    logic [dltq_pkg::TAG_W-1:0]   r_tag [dltq_pkg::QUEUE_DEPTH];
    logic [dltq_pkg::TAG_W-1:0]   n_tag [dltq_pkg::QUEUE_DEPTH];
    logic [dltq_pkg::CNT_W-1:0]   r_count;
    logic [dltq_pkg::CNT_W-1:0]   n_count;
    logic [dltq_pkg::IDX_W-1:0]   r_idx;
    logic [dltq_pkg::SUM_W-1:0]   r_sum;
    logic [dltq_pkg::DELTA_W-1:0] r_delay;
    logic [dltq_pkg::TAG_W-1:0]   r_new_tag;
    logic                         r_m_valid;
    logic                         r_m_kind;
    logic [dltq_pkg::TAG_W-1:0]   r_m_tag;
    logic                         r_m_last;

    logic [dltq_pkg::SUM_W-1:0]   sum_next;
    logic [dltq_pkg::DELTA_W-1:0] fresh;
    logic [dltq_pkg::CNT_W-1:0]   pos;
    logic                         out_free;

    assign out_free = !r_m_valid || i_m_tready;
    assign sum_next = r_sum + dltq_pkg::SUM_W'(r_delta[r_idx]);
    assign fresh = r_delay - r_sum[dltq_pkg::DELTA_W-1:0];
    assign pos = dltq_pkg::CNT_W'(r_idx);

    assign o_status.full = (r_count == dltq_pkg::CNT_W'(dltq_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.head_one = (r_delta[0] == dltq_pkg::DELTA_W'(1));
    assign o_status.walk_end = (pos == r_count);
    assign o_status.walk_hit = (sum_next >= dltq_pkg::SUM_W'(r_delay));
    assign o_status.pop_last = (r_count == dltq_pkg::CNT_W'(1)) || (r_delta[1] != '0);
    assign o_status.out_free = out_free;

    always_comb begin
        n_delta = r_delta;
        n_tag = r_tag;
        n_count = r_count;
        if (i_cmd.insert_shift) begin
            for (int i = 1; i < dltq_pkg::QUEUE_DEPTH; i++) begin
                if ((dltq_pkg::CNT_W'(i) > pos) && (dltq_pkg::CNT_W'(i) <= r_count)) begin
                    n_tag[i] = r_tag[i-1];
                    if (dltq_pkg::CNT_W'(i) == pos + dltq_pkg::CNT_W'(1)) begin
                        n_delta[i] = r_delta[i-1] - fresh;
                    end else begin
                        n_delta[i] = r_delta[i-1];
                    end
                end
            end
            n_delta[r_idx] = fresh;
            n_tag[r_idx] = r_new_tag;
            n_count = r_count + dltq_pkg::CNT_W'(1);
        end else if (i_cmd.tick_dec) begin
            n_delta[0] = r_delta[0] - dltq_pkg::DELTA_W'(1);
        end else if (i_cmd.pop) begin
            for (int i = 0; i < dltq_pkg::QUEUE_DEPTH - 1; i++) begin
                n_delta[i] = r_delta[i+1];
                n_tag[i] = r_tag[i+1];
            end
            n_count = r_count - dltq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_delta <= n_delta;
        r_tag <= n_tag;
        if (i_cmd.start_insert) begin
            r_idx <= '0;
            r_sum <= '0;
            r_delay <= (i_delay == '0) ? dltq_pkg::DELTA_W'(1) : i_delay;
            r_new_tag <= i_tag;
        end else if (i_cmd.walk_adv) begin
            r_idx <= r_idx + dltq_pkg::IDX_W'(1);
            r_sum <= sum_next;
        end
        if (i_cmd.load_reject) begin
            r_m_kind <= dltq_pkg::KIND_REJECTED;
            r_m_tag <= i_tag;
            r_m_last <= 1'b1;
        end else if (i_cmd.pop) begin
            r_m_kind <= dltq_pkg::KIND_EXPIRED;
            r_m_tag <= r_tag[0];
            r_m_last <= o_status.pop_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_reject || i_cmd.pop) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_kind = r_m_kind;
    assign o_m_tag = r_m_tag;
    assign o_m_last = r_m_last;

endmodule

`default_nettype wire

@@ rtl/core/delta_list_timer_queue.sv @@
`default_nettype none

// Timer queue of up to sixteen software timers kept as a delta list. An insert
// transfer (tuser 0) places a timer with its delay and tag; a tick transfer
// (tuser 1) counts one tick and releases every timer that expires, one output
// transfer per tag in deadline order with tlast on the final one. An insert into
// a full queue gives a single output transfer flagged rejected (tuser 1). The
// block takes one input transfer at a time: an insert walks the list one entry
// per cycle and then shifts the new entry in; a tick pops each expired tag once
// the output register is free; a rejected insert loads that register directly.
// Input ready also waits for the output register to be free.
module delta_list_timer_queue (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // delay_ticks [15:0], task_tag [31:16].
    input  wire logic [dltq_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // operation.
    input  wire logic                             i_s_tuser,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // task_tag_out [15:0].
    output logic [dltq_pkg::M_TDATA_W-1:0]        o_m_tdata,
    // kind.
    output logic                                  o_m_tuser,
    output logic                                  o_m_tlast
);

    dltq_pkg::t_cmd               cmd;
    dltq_pkg::t_status            status;
    logic [dltq_pkg::TAG_W-1:0]   m_tag;

    dltq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_operation (i_s_tuser),
        .o_ready     (o_s_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dltq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_delay    (i_s_tdata[dltq_pkg::DELTA_W-1:0]),
        .i_tag      (i_s_tdata[dltq_pkg::DELTA_W+dltq_pkg::TAG_W-1:dltq_pkg::DELTA_W]),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_kind   (o_m_tuser),
        .o_m_tag    (m_tag),
        .o_m_last   (o_m_tlast)
    );

    assign o_m_tdata = dltq_pkg::M_TDATA_W'(m_tag);

endmodule

`default_nettype wire

@@ rtl/core/dltq_checker.sv @@
`default_nettype none

module dltq_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic                           i_s_tuser,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [dltq_pkg::M_TDATA_W-1:0] o_m_tdata,
    input wire logic                           o_m_tuser,
    input wire logic                           o_m_tlast
);

    a_reject_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == dltq_pkg::KIND_REJECTED)) |-> o_m_tlast)
        else $error("rejected insert not marked last");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output transfer changed while stalled");

    a_no_input_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input ready during an expiry burst");

    a_tick_no_immediate_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == dltq_pkg::OP_TICK)) |=> !o_m_tvalid)
        else $error("output right after a tick transfer");

    a_insert_out_is_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == dltq_pkg::OP_INSERT)) |=>
        (!o_m_tvalid || ((o_m_tuser == dltq_pkg::KIND_REJECTED) && o_m_tlast)))
        else $error("insert produced an output other than a rejection");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (.*);

`default_nettype wire

@@ tb/delta_list_timer_queue_checker.sv @@
`default_nettype none

module delta_list_timer_queue_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    input  wire logic                             i_s_tready,
    // delay_ticks [15:0], task_tag [31:16].
    input  wire logic [dltq_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // operation.
    input  wire logic                             i_s_tuser,
    input  wire logic                             i_m_tvalid,
    input  wire logic                             i_m_tready,
    // task_tag_out [15:0].
    input  wire logic [dltq_pkg::M_TDATA_W-1:0]   i_m_tdata,
    // kind.
    input  wire logic                             i_m_tuser,
    input  wire logic                             i_m_tlast,
    output int                                    o_fail_count,
    output int                                    o_pending,
    output int                                    o_checked,
    output int                                    o_rejected
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        kind;
        logic [dltq_pkg::TAG_W-1:0]  tag;
        logic                        last;
    } t_timer_release;

    t_timer_release release_q[$];
    logic [dltq_pkg::DELTA_W-1:0] delta_mem[dltq_pkg::QUEUE_DEPTH];
    logic [dltq_pkg::TAG_W-1:0]   tag_mem[dltq_pkg::QUEUE_DEPTH];
    int live_count = 0;
    int fail_total = 0;
    int checked_total = 0;
    int rejected_total = 0;

    function automatic void place_timer(input logic [15:0] delay, input logic [15:0] tag);
        int pos;
        bit found;
        int unsigned running;
        int unsigned prior;
        logic [15:0] fresh;
        t_timer_release rel;
        if (live_count >= dltq_pkg::QUEUE_DEPTH) begin
            rel.kind = dltq_pkg::KIND_REJECTED;
            rel.tag = tag;
            rel.last = 1'b1;
            release_q.push_back(rel);
            return;
        end
        if (delay == 16'd0) begin
            delay = 16'd1;
        end
        pos = live_count;
        found = 1'b0;
        running = 0;
        prior = 0;
        for (int i = 0; i < live_count; i++) begin
            if (!found) begin
                running += delta_mem[i];
                if (running >= delay) begin
                    pos = i;
                    found = 1'b1;
                end else begin
                    prior = running;
                end
            end
        end
        fresh = delay - prior[15:0];
        for (int i = live_count; i > pos; i--) begin
            delta_mem[i] = delta_mem[i-1];
            tag_mem[i] = tag_mem[i-1];
        end
        delta_mem[pos] = fresh;
        tag_mem[pos] = tag;
        if (pos < live_count) begin
            delta_mem[pos+1] = delta_mem[pos+1] - fresh;
        end
        live_count++;
    endfunction

    function automatic void count_tick();
        int n;
        t_timer_release rel;
        if (live_count == 0) begin
            return;
        end
        delta_mem[0] = delta_mem[0] - 16'd1;
        if (delta_mem[0] != 16'd0) begin
            return;
        end
        n = 0;
        while (n < live_count && delta_mem[n] == 16'd0) begin
            rel.kind = dltq_pkg::KIND_EXPIRED;
            rel.tag = tag_mem[n];
            rel.last = (n + 1 >= live_count) || (delta_mem[n+1] != 16'd0);
            release_q.push_back(rel);
            n++;
        end
        for (int i = 0; i + n < live_count; i++) begin
            delta_mem[i] = delta_mem[i+n];
            tag_mem[i] = tag_mem[i+n];
        end
        live_count -= n;
    endfunction

    always @(posedge i_clk) begin
        t_timer_release want;
        if (!i_rst_n) begin
            live_count = 0;
            release_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                checked_total++;
                if (i_m_tuser == dltq_pkg::KIND_REJECTED) begin
                    rejected_total++;
                end
                if (release_q.size() == 0) begin
                    $error("Unexpected output transfer: kind %0d, task_tag_out %h, last %0d",
                           i_m_tuser, i_m_tdata, i_m_tlast);
                    fail_total++;
                end else begin
                    want = release_q.pop_front();
                    if (i_m_tuser !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, i_m_tuser);
                        fail_total++;
                    end
                    if (i_m_tdata[15:0] !== want.tag) begin
                        $error("task_tag_out mismatch: expected %h, actual %h",
                               want.tag, i_m_tdata[15:0]);
                        fail_total++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d", want.last, i_m_tlast);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == dltq_pkg::OP_INSERT) begin
                    place_timer(i_s_tdata[15:0], i_s_tdata[31:16]);
                end else begin
                    count_tick();
                end
            end
        end
        o_pending <= release_q.size();
        o_fail_count <= fail_total;
        o_checked <= checked_total;
        o_rejected <= rejected_total;
    end

endmodule

`default_nettype wire

@@ tb/tb_delta_list_timer_queue.sv @@
`default_nettype none

module tb_delta_list_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    // delay_ticks [15:0], task_tag [31:16].
    logic [dltq_pkg::S_TDATA_W-1:0] s_tdata = '0;
    // operation.
    logic s_tuser = dltq_pkg::OP_TICK;
    logic m_tvalid;
    logic m_tready = 1'b0;
    // task_tag_out [15:0].
    logic [dltq_pkg::M_TDATA_W-1:0] m_tdata;
    // kind.
    logic m_tuser;
    logic m_tlast;

    int fail_count;
    int pending;
    int checked;
    int rejected;
    int send_idle_pct = 18;
    int recv_idle_pct = 59;
    int insert_count = 0;
    int tick_count = 0;
    int long_count = 0;

    delta_list_timer_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    delta_list_timer_queue_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_rejected   (rejected)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic send_item(input logic op, input logic [15:0] delay, input logic [15:0] tag);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {tag, delay};
        do @(posedge i_clk); while (!s_tready);
        if (op == dltq_pkg::OP_INSERT) begin
            insert_count++;
        end else begin
            tick_count++;
        end
    endtask

    task automatic send_tick();
        send_item(dltq_pkg::OP_TICK, 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_item();
        int roll;
        logic [15:0] delay;
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
            send_tick();
        end else begin
            if (long_count < 4 && $urandom_range(0, 99) < 2) begin
                delay = 16'($urandom_range(0, 65535));
                long_count++;
            end else if ($urandom_range(0, 9) == 0) begin
                delay = 16'($urandom_range(0, 60));
            end else begin
                delay = 16'($urandom_range(0, 6));
            end
            send_item(dltq_pkg::OP_INSERT, delay, 16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_tick();
        send_item(dltq_pkg::OP_INSERT, 16'd0, 16'h0000);
        send_item(dltq_pkg::OP_INSERT, 16'd1, 16'hFFFF);
        send_item(dltq_pkg::OP_INSERT, 16'hFFFF, 16'hA5A5);
        long_count++;
        send_item(dltq_pkg::OP_INSERT, 16'd3, 16'h5A5A);
        send_tick();
        wait_drained();
        for (int i = 0; i < 14; i++) begin
            send_item(dltq_pkg::OP_INSERT, 16'd2, 16'h1111 * i[15:0] + 16'h0101);
        end
        send_item(dltq_pkg::OP_INSERT, 16'd1, 16'h1234);
        send_tick();
        send_tick();
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 59;
                end
                1: begin
                    send_idle_pct = 59;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int k = 0; k < 90; k++) begin
                if (k % 50 == 49) begin
                    wait_drained();
                end
                if (k % 30 == 15) begin
                    repeat (10) begin
                        send_item(dltq_pkg::OP_INSERT, 16'($urandom_range(0, 2)),
                                  16'($urandom_range(0, 65535)));
                    end
                end
                random_item();
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d inserts and %0d ticks under three idle patterns.",
                 insert_count, tick_count);
        $display("Compared %0d output transfers, %0d of them full-queue rejects.",
                 checked, rejected);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
